// ===== rtl/npps_pkg.sv =====
// shared types and constants of the non-preemptive priority scheduler
package npps_pkg;

    // table capacity, 1 to 64 jobs
    localparam int MAX_JOBS   = 32;
    localparam int IDX_W      = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W      = $clog2(MAX_JOBS + 1);

    localparam int ID_W       = 8;
    localparam int TIME_W     = 16;
    localparam int PRIO_W     = 8;
    localparam int RUN_W      = 24;
    localparam int DIFF_W     = 25;
    localparam int SUM_W      = 32;
    localparam int PAD_W      = 4;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 200;

    // divider walks one quotient bit per cycle
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // one stored job, id in the low bits as on the input bus
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] arrival;
        logic [ID_W-1:0]   id;
    } t_job;

    // one schedule row, out_id in the low bits as on the output bus
    typedef struct packed {
        logic [PAD_W-1:0]         pad;
        logic [DIFF_W-1:0]        avg_tat;
        logic [DIFF_W-1:0]        avg_wait;
        logic [DIFF_W-1:0]        tat;
        logic [DIFF_W-1:0]        wait_t;
        logic [RUN_W-1:0]         finish;
        logic [RUN_W-1:0]         start;
        logic [TIME_W-1:0]        burst;
        logic [TIME_W-1:0]        arrival;
        logic [PRIO_W-1:0]        prio;
        logic [ID_W-1:0]          id;
    } t_row;

    // divider request and response
    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [CNT_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== rtl/npps_div.sv =====
// iterative signed-by-unsigned divider, truncating toward zero, one bit per cycle
module npps_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  npps_pkg::t_div_req   i_req,
    output npps_pkg::t_div_rsp   o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic                           r_neg;
    logic [npps_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [npps_pkg::CNT_W-1:0]     r_rem;
    logic [npps_pkg::CNT_W-1:0]     r_div;
    logic [npps_pkg::SUM_W-1:0]     r_quo;

    logic [npps_pkg::SUM_W-1:0]     w_mag;
    logic [npps_pkg::CNT_W:0]       w_shift;
    logic [npps_pkg::CNT_W:0]       w_diff;
    logic                           w_ge;

    // magnitude of the dividend
    assign w_mag = i_req.dividend[npps_pkg::SUM_W-1] ?
                   (~i_req.dividend + 1'b1) : i_req.dividend;

    // restoring step: bring down the next dividend bit and try a subtract
    assign w_shift = {r_rem, r_quo[npps_pkg::SUM_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == npps_pkg::DIV_CNT_W'(npps_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= w_mag;
            r_rem <= '0;
            r_neg <= i_req.dividend[npps_pkg::SUM_W-1];
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[npps_pkg::SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[npps_pkg::CNT_W-1:0] : w_shift[npps_pkg::CNT_W-1:0];
        end
    end

    // restore the sign on the way out
    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? signed'(~r_quo + 1'b1) : signed'(r_quo);

endmodule

// ===== rtl/nonpreemptive_priority_schedule_top.sv =====
// top level: job table, insertion and emission sequencer, output register
//
// Non-preemptive priority scheduler. Jobs arrive on the s_axis channel, one
// transfer each: tdata holds process_id, arrival, burst and priority, tlast
// marks the final job of a batch. Jobs are kept in a table sorted by
// ascending priority value, equal values in arrival order; jobs past the
// table capacity are dropped. After the job with tlast, one row per stored
// job leaves on m_axis in schedule order, tlast set on the final row, which
// also carries the truncated average wait and turnaround. The table then
// empties for the next batch.
// Insertion: each entry with a higher priority value is read in S_INS_RD
// and written one place up in S_INS_CMP; s_axis tready stays low from the
// transfer at least until the job is written. A job dropped at a full
// table takes no insertion pass.
// Emission: each row passes the table read port (S_EMIT_RD, S_EMIT_CALC)
// into the output register and is held there until taken; the final row
// first waits for two divisions on the shared serial divider.
// A stalled m_axis holds the row and the whole block. After reset the table
// is empty and s_axis tready is high; no clearing pass is needed.
module nonpreemptive_priority_schedule_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // process_id[7:0], arrival_time[23:8], burst_time[39:24], priority_level[47:40]
    input  logic [47:0]  i_s_axis_tdata,
    input  logic         i_s_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // out_id[7:0], out_priority[15:8], out_arrival[31:16], out_burst[47:32],
    // start_time[71:48], finish_time[95:72], wait_time[120:96],
    // turnaround_time[145:121], average_wait[170:146],
    // average_turnaround[195:171], zero[199:196]
    output logic [199:0] o_m_axis_tdata,
    output logic         o_m_axis_tlast
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_INS_RD    = 8'b0000_0010,
        S_INS_CMP   = 8'b0000_0100,
        S_EMIT_RD   = 8'b0000_1000,
        S_EMIT_CALC = 8'b0001_0000,
        S_DIV_W     = 8'b0010_0000,
        S_DIV_T     = 8'b0100_0000,
        S_OUT       = 8'b1000_0000
    } t_state;

    t_state                                r_state, n_state;
    logic [npps_pkg::CNT_W-1:0]            r_count, n_count;
    logic [npps_pkg::CNT_W-1:0]            r_pos, n_pos;
    logic [npps_pkg::CNT_W-1:0]            r_k, n_k;
    logic [npps_pkg::CNT_W-1:0]            r_n, n_n;
    logic [npps_pkg::RUN_W-1:0]            r_run, n_run;
    logic signed [npps_pkg::SUM_W-1:0]     r_wsum, n_wsum;
    logic signed [npps_pkg::SUM_W-1:0]     r_tsum, n_tsum;
    logic                                  r_m_valid, n_m_valid;
    logic                                  r_m_last, n_m_last;
    logic                                  r_div_start, n_div_start;
    logic signed [npps_pkg::SUM_W-1:0]     r_div_num, n_div_num;
    npps_pkg::t_job                        r_new, n_new;
    logic                                  r_last, n_last;
    npps_pkg::t_row                        r_row, n_row;

    // job table
    npps_pkg::t_job                        r_mem [npps_pkg::MAX_JOBS];
    npps_pkg::t_job                        r_rd;
    logic                                  w_we;
    logic [npps_pkg::IDX_W-1:0]            w_waddr;
    logic [npps_pkg::IDX_W-1:0]            w_raddr;
    npps_pkg::t_job                        w_wdata;
    logic [npps_pkg::CNT_W-1:0]            w_pos_dec;

    // row arithmetic
    logic [npps_pkg::DIFF_W-1:0]           w_finish;
    logic signed [npps_pkg::DIFF_W-1:0]    w_wait;
    logic signed [npps_pkg::DIFF_W:0]      w_tat;
    logic                                  w_final;

    npps_pkg::t_div_req                    div_req;
    npps_pkg::t_div_rsp                    div_rsp;

    npps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign div_req.start    = r_div_start;
    assign div_req.dividend = r_div_num;
    assign div_req.divisor  = r_n;

    // table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    assign w_pos_dec = r_pos - 1'b1;

    // times of the row just read: start is the running sum of bursts
    assign w_finish = {1'b0, r_run} + npps_pkg::DIFF_W'(r_rd.burst);
    assign w_wait   = signed'({1'b0, r_run} - npps_pkg::DIFF_W'(r_rd.arrival));
    assign w_tat    = signed'({1'b0, w_finish} - (npps_pkg::DIFF_W + 1)'(r_rd.arrival));
    assign w_final  = (r_k + 1'b1) == r_n;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_k         = r_k;
        n_n         = r_n;
        n_run       = r_run;
        n_wsum      = r_wsum;
        n_tsum      = r_tsum;
        n_m_valid   = r_m_valid;
        n_m_last    = r_m_last;
        n_div_start = 1'b0;
        n_div_num   = r_div_num;
        n_new       = r_new;
        n_last      = r_last;
        n_row       = r_row;
        w_we        = 1'b0;
        w_waddr     = r_pos[npps_pkg::IDX_W-1:0];
        w_wdata     = r_new;
        w_raddr     = r_k[npps_pkg::IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_new  = npps_pkg::t_job'(i_s_axis_tdata);
                    n_last = i_s_axis_tlast;
                    if (r_count < npps_pkg::CNT_W'(npps_pkg::MAX_JOBS)) begin
                        n_pos   = r_count;
                        n_state = S_INS_RD;
                    end else if (i_s_axis_tlast) begin
                        // table full: drop the job, still emit the batch
                        n_n     = r_count;
                        n_k     = '0;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_INS_RD: begin
                w_raddr = w_pos_dec[npps_pkg::IDX_W-1:0];
                if (r_pos == '0) begin
                    // reached the head of the table
                    w_we    = 1'b1;
                    n_count = r_count + 1'b1;
                    n_n     = r_count + 1'b1;
                    n_k     = '0;
                    n_state = r_last ? S_EMIT_RD : S_IDLE;
                end else begin
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                w_we = 1'b1;
                if (r_rd.prio <= r_new.prio) begin
                    // new job goes right after this entry
                    n_count = r_count + 1'b1;
                    n_n     = r_count + 1'b1;
                    n_k     = '0;
                    n_state = r_last ? S_EMIT_RD : S_IDLE;
                end else begin
                    // move the entry one place up and keep looking
                    w_wdata = r_rd;
                    n_pos   = w_pos_dec;
                    n_state = S_INS_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_CALC;
            end
            S_EMIT_CALC: begin
                n_run          = w_finish[npps_pkg::RUN_W-1:0];
                n_wsum         = r_wsum + npps_pkg::SUM_W'(w_wait);
                n_tsum         = r_tsum + npps_pkg::SUM_W'(w_tat);
                n_row.pad      = '0;
                n_row.avg_tat  = '0;
                n_row.avg_wait = '0;
                n_row.tat      = w_tat[npps_pkg::DIFF_W-1:0];
                n_row.wait_t   = w_wait;
                n_row.finish   = w_finish[npps_pkg::RUN_W-1:0];
                n_row.start    = r_run;
                n_row.burst    = r_rd.burst;
                n_row.arrival  = r_rd.arrival;
                n_row.prio     = r_rd.prio;
                n_row.id       = r_rd.id;
                if (w_final) begin
                    n_div_start = 1'b1;
                    n_div_num   = n_wsum;
                    n_state     = S_DIV_W;
                end else begin
                    n_m_valid = 1'b1;
                    n_m_last  = 1'b0;
                    n_state   = S_OUT;
                end
            end
            S_DIV_W: begin
                if (div_rsp.done) begin
                    n_row.avg_wait = div_rsp.quotient[npps_pkg::DIFF_W-1:0];
                    n_div_start    = 1'b1;
                    n_div_num      = r_tsum;
                    n_state        = S_DIV_T;
                end
            end
            S_DIV_T: begin
                if (div_rsp.done) begin
                    n_row.avg_tat = div_rsp.quotient[npps_pkg::DIFF_W-1:0];
                    n_m_valid     = 1'b1;
                    n_m_last      = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_OUT: begin
                if (i_m_axis_tready) begin
                    n_m_valid = 1'b0;
                    if (r_m_last) begin
                        // batch done, empty the table
                        n_count = '0;
                        n_run   = '0;
                        n_wsum  = '0;
                        n_tsum  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_k         <= '0;
            r_n         <= '0;
            r_run       <= '0;
            r_wsum      <= '0;
            r_tsum      <= '0;
            r_m_valid   <= 1'b0;
            r_m_last    <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_k         <= n_k;
            r_n         <= n_n;
            r_run       <= n_run;
            r_wsum      <= n_wsum;
            r_tsum      <= n_tsum;
            r_m_valid   <= n_m_valid;
            r_m_last    <= n_m_last;
            r_div_start <= n_div_start;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_new     <= n_new;
        r_last    <= n_last;
        r_row     <= n_row;
        r_div_num <= n_div_num;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_row;
    assign o_m_axis_tlast  = r_m_last;

    // one item at a time: no input taken while a row is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !o_m_axis_tvalid)
        else $error("input ready while a row is pending");

    // table never holds more than its capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= npps_pkg::CNT_W'(npps_pkg::MAX_JOBS))
        else $error("entry count above capacity");

    // the final row is the n-th row of the batch
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> ((r_k + 1'b1) == r_n))
        else $error("final row flagged at wrong position");

    // divider is only started when free
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // a finished division is only seen while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV_W || r_state == S_DIV_T))
        else $error("division finished outside a wait state");

endmodule
